@@ rtl/rqmf_pkg.sv @@
// ----------------------------------------------------------------------------
// rqmf_pkg
// Shared codes and the result bundle of the ring queue with move-to-front.
// ----------------------------------------------------------------------------
package rqmf_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int OCC_W = 5;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_POS   = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic                    is_empty;
    logic                    is_full;
    logic [OCC_W-1:0]        occupancy;
    logic [ST_W-1:0]         status;
  } res_t;

endpackage

@@ rtl/rqmf_ram.sv @@
// ----------------------------------------------------------------------------
// rqmf_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rqmf_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rqmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqmf_ctrl
// Queue pointers and sequencer: runs each operation against the slot RAM,
// shifts slots one per cycle for a move, then reads head and tail.
// ----------------------------------------------------------------------------
module rqmf_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [rqmf_pkg::OP_W-1:0]      in_op,
  input  logic signed [rqmf_pkg::VAL_W-1:0] in_value,
  input  logic [rqmf_pkg::POS_W-1:0]     in_position,
  output logic                           idle,
  output logic                           res_valid,
  output rqmf_pkg::res_t                 res,
  input  logic                           res_take,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [DATA_WIDTH-1:0]          mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [DATA_WIDTH-1:0]          mem_rdata
);

  import rqmf_pkg::*;

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW:0] DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MVT  = 3'd1;
  localparam logic [2:0] S_MVS  = 3'd2;
  localparam logic [2:0] S_MVP  = 3'd3;
  localparam logic [2:0] S_RDH  = 3'd4;
  localparam logic [2:0] S_RDT  = 3'd5;
  localparam logic [2:0] S_RDB  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]                   state_r,  state_nxt;
  logic [AW-1:0]                head_r,   head_nxt;
  logic [AW-1:0]                tail_r,   tail_nxt;
  logic [CW-1:0]                count_r,  count_nxt;
  logic [AW-1:0]                idx_r,    idx_nxt;
  logic [ST_W-1:0]              status_r, status_nxt;
  logic signed [DATA_WIDTH-1:0] tmp_r,    tmp_nxt;
  logic signed [DATA_WIDTH-1:0] front_r,  front_nxt;
  logic signed [DATA_WIDTH-1:0] back_r,   back_nxt;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [AW-1:0]   pos_m1;
  logic [AW-1:0]   idx_m1;
  logic [AW-1:0]   idx_m2;
  logic            empty;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  assign pos_x  = CMPW'(in_position);
  assign cnt_x  = CMPW'(count_r);
  assign pos_m1 = AW'(pos_x - CMPW'(1));
  assign idx_m1 = idx_r - AW'(1);
  assign idx_m2 = idx_m1 - AW'(1);
  assign empty  = (count_r == '0);
  assign idle   = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    tmp_nxt    = tmp_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = tmp_r;
    mem_re     = 1'b0;
    mem_raddr  = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          state_nxt  = S_RDH;
          case (in_op)
            OP_ENQ: begin
              if (count_r == DEPTH_C) begin
                status_nxt = ST_FULL;
              end else begin
                tail_nxt  = wrap_add(tail_r, AW'(1));
                mem_we    = 1'b1;
                mem_waddr = wrap_add(tail_r, AW'(1));
                mem_wdata = DATA_WIDTH'(in_value);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_DEQ: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt  = wrap_add(head_r, AW'(1));
                count_nxt = count_r - CW'(1);
              end
            end
            OP_MOVE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                status_nxt = ST_POS;
              end else if (pos_x != CMPW'(1)) begin
                mem_re    = 1'b1;
                mem_raddr = wrap_add(head_r, pos_m1);
                idx_nxt   = pos_m1;
                state_nxt = S_MVT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MVT: begin
        tmp_nxt   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = wrap_add(head_r, idx_m1);
        state_nxt = S_MVS;
      end
      S_MVS: begin
        mem_we    = 1'b1;
        mem_waddr = wrap_add(head_r, idx_r);
        mem_wdata = mem_rdata;
        if (idx_r > AW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = wrap_add(head_r, idx_m2);
          idx_nxt   = idx_m1;
        end else begin
          state_nxt = S_MVP;
        end
      end
      S_MVP: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        mem_wdata = tmp_r;
        state_nxt = S_RDH;
      end
      S_RDH: begin
        mem_re    = 1'b1;
        mem_raddr = head_r;
        state_nxt = S_RDT;
      end
      S_RDT: begin
        front_nxt = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = tail_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        back_nxt  = mem_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= AW'(DEPTH - 1);
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    tmp_r    <= tmp_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
  end

  assign res_valid       = (state_r == S_FIN);
  assign res.front_value = empty ? '0 : VAL_W'(front_r);
  assign res.back_value  = empty ? '0 : VAL_W'(back_r);
  assign res.is_empty    = empty;
  assign res.is_full     = (count_r == DEPTH_C);
  assign res.occupancy   = OCC_W'(count_r);
  assign res.status      = status_r;

endmodule

@@ rtl/ring_queue_move_nth_front_unit.sv @@
// ----------------------------------------------------------------------------
// ring_queue_move_nth_front_unit
// Circular FIFO with enqueue, dequeue, move-nth-to-front and peek; one result
// beat per input beat.
// Sequence: each accepted beat reads head and tail from the slot RAM, then the
// result is registered into the output; a move of position p >= 2 first shifts
// slots one at a time. A new beat is taken only after the last result is taken.
// Reset (sync, active low): queue empty, head 0, tail DEPTH-1; no result held.
// ----------------------------------------------------------------------------
module ring_queue_move_nth_front_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rqmf_pkg::OP_W-1:0]           in_op,
  input  logic signed [rqmf_pkg::VAL_W-1:0]   in_value,
  input  logic [rqmf_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rqmf_pkg::VAL_W-1:0]   out_front_value,
  output logic signed [rqmf_pkg::VAL_W-1:0]   out_back_value,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic [rqmf_pkg::OCC_W-1:0]          out_occupancy,
  output logic [rqmf_pkg::ST_W-1:0]           out_status
);

  import rqmf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  idle;
  logic                  res_valid;
  res_t                  res;
  logic                  res_take;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  rqmf_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rqmf_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_op       (in_op),
    .in_value    (in_value),
    .in_position (in_position),
    .idle        (idle),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  assign in_stall = !idle;
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = out_r.front_value;
  assign out_back_value  = out_r.back_value;
  assign out_is_empty    = out_r.is_empty;
  assign out_is_full     = out_r.is_full;
  assign out_occupancy   = out_r.occupancy;
  assign out_status      = out_r.status;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted beat did not start a sequence");

  a_empty_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("queue reported empty and full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_front_value == '0 && out_back_value == '0))
    else $error("empty queue with nonzero front or back");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_is_full)
    else $error("enqueue rejected while not full");

endmodule

@@ tb/tb_ring_queue_move_nth_front_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ring_queue_move_nth_front_unit
// Self-checking bench for the ring queue with move-to-front. A shadow queue
// predicts the report for every accepted command beat, and each result beat is
// checked field by field against the oldest prediction. Directed corners come
// first, then ~600 random beats in fill, drain and mixed phases, with random
// idling on both channels.
// ----------------------------------------------------------------------------

class ring_queue_shadow;
  localparam int DEPTH = 16;

  logic signed [rqmf_pkg::VAL_W-1:0] slots [DEPTH];
  int head;
  int tail;
  int count;
  rqmf_pkg::res_t report_q [$];
  int errors;
  int reports_checked;
  int op_seen [4];
  int st_seen [4];

  function new();
    head = 0;
    tail = DEPTH - 1;
    count = 0;
    errors = 0;
    reports_checked = 0;
  endfunction

  // predict the report of one accepted command beat
  function void apply_op(logic [rqmf_pkg::OP_W-1:0] op,
                         logic signed [rqmf_pkg::VAL_W-1:0] val,
                         logic [rqmf_pkg::POS_W-1:0] pos);
    rqmf_pkg::res_t rep;
    logic [rqmf_pkg::ST_W-1:0] st;
    logic signed [rqmf_pkg::VAL_W-1:0] picked;
    int k;
    st = rqmf_pkg::ST_OK;
    case (op)
      rqmf_pkg::OP_ENQ: begin
        if (count >= DEPTH) begin
          st = rqmf_pkg::ST_FULL;
        end else begin
          tail = (tail + 1) % DEPTH;
          slots[tail] = val;
          count++;
        end
      end
      rqmf_pkg::OP_DEQ: begin
        if (count == 0) begin
          st = rqmf_pkg::ST_EMPTY;
        end else begin
          count--;
          head = (head + 1) % DEPTH;
        end
      end
      rqmf_pkg::OP_MOVE: begin
        if (count == 0) begin
          st = rqmf_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > count) begin
          st = rqmf_pkg::ST_POS;
        end else begin
          picked = slots[(head + pos - 1) % DEPTH];
          for (k = pos - 1; k > 0; k--) begin
            slots[(head + k) % DEPTH] = slots[(head + k - 1) % DEPTH];
          end
          slots[head] = picked;
        end
      end
      default: ;
    endcase
    rep.front_value = (count == 0) ? '0 : slots[head];
    rep.back_value  = (count == 0) ? '0 : slots[tail];
    rep.is_empty    = (count == 0);
    rep.is_full     = (count == DEPTH);
    rep.occupancy   = count[rqmf_pkg::OCC_W-1:0];
    rep.status      = st;
    report_q.push_back(rep);
    op_seen[op]++;
    st_seen[st]++;
  endfunction

  function void compare_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_report(rqmf_pkg::res_t got);
    rqmf_pkg::res_t want;
    if (report_q.size() == 0) begin
      $error("result beat with no prediction pending");
      errors++;
      return;
    end
    want = report_q.pop_front();
    reports_checked++;
    compare_field("front_value", want.front_value, got.front_value);
    compare_field("back_value", want.back_value, got.back_value);
    compare_field("is_empty", want.is_empty, got.is_empty);
    compare_field("is_full", want.is_full, got.is_full);
    compare_field("occupancy", want.occupancy, got.occupancy);
    compare_field("status", want.status, got.status);
  endfunction
endclass

module tb_ring_queue_move_nth_front_unit;
  import rqmf_pkg::*;

  localparam int DEPTH     = 16;
  localparam int N_RANDOM  = 600;
  localparam int MAX_CYC   = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_op = OP_PEEK;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_front_value;
  logic signed [VAL_W-1:0] out_back_value;
  logic out_is_empty;
  logic out_is_full;
  logic [OCC_W-1:0] out_occupancy;
  logic [ST_W-1:0] out_status;

  ring_queue_shadow shadow;
  logic no_idle = 1'b0;
  int cycles = 0;

  ring_queue_move_nth_front_unit #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(32)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_front_value(out_front_value),
    .out_back_value(out_back_value),
    .out_is_empty(out_is_empty),
    .out_is_full(out_is_full),
    .out_occupancy(out_occupancy),
    .out_status(out_status)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYC) begin
      $display("[ring_queue_move_nth_front_unit] ERROR");
      $finish;
    end
  end

  // result side: check accepted beats, then roll the next stall
  always @(posedge clk) begin
    rqmf_pkg::res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.front_value = out_front_value;
      got.back_value  = out_back_value;
      got.is_empty    = out_is_empty;
      got.is_full     = out_is_full;
      got.occupancy   = out_occupancy;
      got.status      = out_status;
      shadow.check_report(got);
    end
    out_stall <= !no_idle && ($urandom_range(99) < 28);
  end

  task automatic push_beat(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                           logic [POS_W-1:0] pos);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.apply_op(op, val, pos);
  endtask

  task automatic run_directed();
    push_beat(OP_PEEK, 0, 0);
    push_beat(OP_DEQ, 0, 0);
    push_beat(OP_MOVE, 0, 1);
    push_beat(OP_MOVE, 0, 0);
    push_beat(OP_ENQ, 32'sh7fffffff, 0);
    push_beat(OP_ENQ, 32'sh80000000, 31);
    push_beat(OP_ENQ, 0, 0);
    push_beat(OP_ENQ, -1, 0);
    push_beat(OP_ENQ, 1, 0);
    push_beat(OP_MOVE, 0, 0);
    push_beat(OP_MOVE, 0, 6);
    push_beat(OP_MOVE, -1, 31);
    push_beat(OP_MOVE, 0, 1);
    push_beat(OP_MOVE, 0, 5);
    push_beat(OP_MOVE, 0, 3);
    push_beat(OP_MOVE, 0, 2);
    push_beat(OP_PEEK, -1, 31);
    push_beat(OP_DEQ, 0, 0);
  endtask

  // phases of 50 beats: filling, draining, mixed
  task automatic run_random(int n);
    int i;
    int roll;
    int enq_pct;
    int deq_pct;
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    for (i = 0; i < n; i++) begin
      no_idle <= (i >= 250 && i < 400);
      case ((i / 50) % 3)
        0: begin enq_pct = 60; deq_pct = 15; end
        1: begin enq_pct = 15; deq_pct = 60; end
        default: begin enq_pct = 35; deq_pct = 30; end
      endcase
      roll = $urandom_range(99);
      if (roll < enq_pct) op = OP_ENQ;
      else if (roll < enq_pct + deq_pct) op = OP_DEQ;
      else if (roll < 95) op = OP_MOVE;
      else op = OP_PEEK;
      case ($urandom_range(9))
        0: val = 32'sh7fffffff;
        1: val = 32'sh80000000;
        default: val = $urandom;
      endcase
      if (shadow.count > 0 && $urandom_range(99) < 80)
        pos = POS_W'($urandom_range(shadow.count, 1));
      else
        pos = POS_W'($urandom_range(31, 0));
      push_beat(op, val, pos);
    end
  endtask

  initial begin
    shadow = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(N_RANDOM);
    in_valid <= 1'b0;
    no_idle  <= 1'b0;
    while (shadow.report_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Checked %0d reports: %0d enqueue, %0d dequeue, %0d move, %0d peek.",
             shadow.reports_checked, shadow.op_seen[OP_ENQ], shadow.op_seen[OP_DEQ],
             shadow.op_seen[OP_MOVE], shadow.op_seen[OP_PEEK]);
    $display("Status mix: %0d ok, %0d full, %0d empty, %0d bad position.",
             shadow.st_seen[ST_OK], shadow.st_seen[ST_FULL],
             shadow.st_seen[ST_EMPTY], shadow.st_seen[ST_POS]);
    if (shadow.errors == 0 && shadow.report_q.size() == 0) begin
      $display("[ring_queue_move_nth_front_unit] OK");
    end else begin
      $display("[ring_queue_move_nth_front_unit] ERROR");
    end
    $finish;
  end
endmodule
